>>> rtl/tclcp_pkg.sv
// Package with the transfer types and case codes of the two-contact LCP solver.
`default_nettype none

package tclcp_pkg;

  localparam int unsigned FracBitsDefault = 16;

  localparam logic [1:0] CASE_FULL = 2'd0;
  localparam logic [1:0] CASE_X1   = 2'd1;
  localparam logic [1:0] CASE_X2   = 2'd2;
  localparam logic [1:0] CASE_ZERO = 2'd3;

  typedef struct packed {
    logic signed [31:0] a11;
    logic signed [31:0] a21;
    logic signed [31:0] a12;
    logic signed [31:0] a22;
    logic signed [31:0] inv11;
    logic signed [31:0] inv21;
    logic signed [31:0] inv12;
    logic signed [31:0] inv22;
    logic signed [31:0] bias1;
    logic signed [31:0] bias2;
  } lcp_in_t;

  typedef struct packed {
    logic signed [31:0] impulse1;
    logic signed [31:0] impulse2;
    logic               solved;
    logic [1:0]         case_taken;
  } lcp_out_t;

endpackage

`default_nettype wire

>>> rtl/two_contact_lcp_solver_top.sv
// Pipelined 2x2 linear complementarity solver for a two-contact block.
//
//  Channel  Direction  Handshake                 Payload
//  in       receive    in_valid_i / in_stall_o   in_data_i  (lcp_in_t)
//  out      send       out_valid_o / out_stall_i out_data_o (lcp_out_t)
//
// One transfer is taken every cycle unless a result waits and is stalled at the output.
// The pipeline is mostly the two restoring dividers, one quotient bit per stage.
// The whole pipeline advances together and halts while a result waits and is stalled.
// Reset clears the valid bits only.
`default_nettype none

module two_contact_lcp_solver_top
  import tclcp_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire lcp_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output lcp_out_t      out_data_o
);

  localparam int unsigned NW = 32 + FRAC_BITS;

  typedef struct packed {
    logic signed [31:0] a21;
    logic signed [31:0] a12;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
    logic               nz1;
    logic               nz2;
    logic               full_ok;
    logic signed [31:0] f1;
    logic signed [31:0] f2;
  } side_t;

  typedef struct packed {
    side_t          sd;
    logic           neg1;
    logic           neg2;
    logic [31:0]    d1;
    logic [31:0]    d2;
    logic [31:0]    r1;
    logic [31:0]    r2;
    logic [NW-1:0]  q1;
    logic [NW-1:0]  q2;
  } div_t;

  function automatic logic [32+NW:0] div_bit(logic [31:0] r, logic [NW-1:0] q,
                                            logic [31:0] d);
    logic [32:0] t;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] rn;
    t    = {r, q[NW-1]};
    diff = t - {1'b0, d};
    ge   = (t >= {1'b0, d});
    rn   = ge ? diff[31:0] : t[31:0];
    return {1'b0, rn, q[NW-2:0], ge};
  endfunction

  function automatic div_t div_step(div_t s);
    div_t        o;
    logic [32+NW:0] a;
    logic [32+NW:0] b;
    o    = s;
    a    = div_bit(s.r1, s.q1, s.d1);
    b    = div_bit(s.r2, s.q2, s.d2);
    o.r1 = a[31+NW:NW];
    o.q1 = a[NW-1:0];
    o.r2 = b[31+NW:NW];
    o.q2 = b[NW-1:0];
    return o;
  endfunction

  function automatic logic signed [31:0] quot_sat(logic [NW-1:0] q, logic neg);
    logic signed [31:0] v;
    if (neg) begin
      v = (q > {{(NW-32){1'b0}}, 32'h8000_0000}) ? 32'sh8000_0000 : -$signed(q[31:0]);
    end else begin
      v = (q > {{(NW-32){1'b0}}, 32'h7fff_ffff}) ? 32'sh7fff_ffff : $signed(q[31:0]);
    end
    return v;
  endfunction

  function automatic logic signed [31:0] sat66(logic signed [65:0] v);
    logic signed [31:0] o;
    if (v > 66'sd2147483647) begin
      o = 32'sh7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      o = 32'sh8000_0000;
    end else begin
      o = v[31:0];
    end
    return o;
  endfunction

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Stage 0: register inputs, full-case products, divider set-up.
  logic               v0_q;
  div_t               s0_q, s0_d;
  logic signed [63:0] p11_q, p12_q, p21_q, p22_q;

  always_comb begin
    s0_d         = '0;
    s0_d.sd.a21  = in_data_i.a21;
    s0_d.sd.a12  = in_data_i.a12;
    s0_d.sd.b1   = in_data_i.bias1;
    s0_d.sd.b2   = in_data_i.bias2;
    s0_d.sd.nz1  = (in_data_i.a11 != 32'sd0);
    s0_d.sd.nz2  = (in_data_i.a22 != 32'sd0);
    s0_d.neg1    = (in_data_i.bias1 > 32'sd0) ^ in_data_i.a11[31];
    s0_d.neg2    = (in_data_i.bias2 > 32'sd0) ^ in_data_i.a22[31];
    s0_d.d1      = mag32(in_data_i.a11);
    s0_d.d2      = mag32(in_data_i.a22);
    s0_d.q1      = {mag32(in_data_i.bias1), {FRAC_BITS{1'b0}}};
    s0_d.q2      = {mag32(in_data_i.bias2), {FRAC_BITS{1'b0}}};
  end

  // Division stages 1..NW; stage 1 also finishes the full case.
  logic [NW:1] vd_q;
  div_t        dv_q [NW:1];
  div_t        dv1_d;
  logic signed [65:0] fs1, fs2;

  always_comb begin
    fs1   = (-66'(p11_q) - 66'(p12_q)) >>> FRAC_BITS;
    fs2   = (-66'(p21_q) - 66'(p22_q)) >>> FRAC_BITS;
    dv1_d = div_step(s0_q);
    dv1_d.sd.f1      = sat66(fs1);
    dv1_d.sd.f2      = sat66(fs2);
    dv1_d.sd.full_ok = !dv1_d.sd.f1[31] && !dv1_d.sd.f2[31];
  end

  // Quotient sign and saturation, then the check products.
  logic               vq_q, vm_q;
  side_t              sq_q, sm_q;
  logic signed [31:0] cq1_q, cq2_q, cm1_q, cm2_q;
  logic signed [63:0] m1_q, m2_q;

  // Output stage.
  lcp_out_t           out_d, out_q;
  logic               vo_q;
  logic signed [64:0] y1, y2;

  always_comb begin
    y2 = ($signed({m1_q[63], m1_q}) >>> FRAC_BITS) + 65'(sm_q.b2);
    y1 = ($signed({m2_q[63], m2_q}) >>> FRAC_BITS) + 65'(sm_q.b1);
    out_d = '0;
    if (sm_q.full_ok) begin
      out_d.impulse1   = sm_q.f1;
      out_d.impulse2   = sm_q.f2;
      out_d.solved     = 1'b1;
      out_d.case_taken = CASE_FULL;
    end else if (sm_q.nz1 && !cm1_q[31] && !y2[64]) begin
      out_d.impulse1   = cm1_q;
      out_d.solved     = 1'b1;
      out_d.case_taken = CASE_X1;
    end else if (sm_q.nz2 && !cm2_q[31] && !y1[64]) begin
      out_d.impulse2   = cm2_q;
      out_d.solved     = 1'b1;
      out_d.case_taken = CASE_X2;
    end else begin
      out_d.solved     = !sm_q.b1[31] && !sm_q.b2[31];
      out_d.case_taken = CASE_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      vd_q <= '0;
      vq_q <= 1'b0;
      vm_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      vd_q <= {vd_q[NW-1:1], v0_q};
      vq_q <= vd_q[NW];
      vm_q <= vq_q;
      vo_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q    <= s0_d;
      p11_q   <= in_data_i.inv11 * in_data_i.bias1;
      p12_q   <= in_data_i.inv12 * in_data_i.bias2;
      p21_q   <= in_data_i.inv21 * in_data_i.bias1;
      p22_q   <= in_data_i.inv22 * in_data_i.bias2;
      dv_q[1] <= dv1_d;
      for (int k = 2; k <= NW; k++) begin
        dv_q[k] <= div_step(dv_q[k-1]);
      end
      sq_q    <= dv_q[NW].sd;
      cq1_q   <= quot_sat(dv_q[NW].q1, dv_q[NW].neg1);
      cq2_q   <= quot_sat(dv_q[NW].q2, dv_q[NW].neg2);
      sm_q    <= sq_q;
      cm1_q   <= cq1_q;
      cm2_q   <= cq2_q;
      m1_q    <= sq_q.a21 * cq1_q;
      m2_q    <= sq_q.a12 * cq2_q;
      out_q   <= out_d;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output is free");

  a_zero_case: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.case_taken == CASE_ZERO) |->
      (out_data_o.impulse1 == 32'sd0 && out_data_o.impulse2 == 32'sd0))
    else $error("zero case with a nonzero impulse");

  a_single_contact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.case_taken == CASE_X1 ||
                     out_data_o.case_taken == CASE_X2)) |->
      (out_data_o.solved && !out_data_o.impulse1[31] && !out_data_o.impulse2[31]))
    else $error("single-contact case without a non-negative solution");

  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the pipelined two-contact LCP solver.
`timescale 1ns / 1ps

module testbench;
  import tclcp_pkg::*;

  localparam int unsigned FracBits = FracBitsDefault;
  localparam int unsigned Latency = 36 + FracBits;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  lcp_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  lcp_out_t out_data_o;

  lcp_out_t solution_q[$];
  int       n_errors = 0;
  int       hold_cycles = 0;
  bit       stall_random = 1'b1;

  two_contact_lcp_solver_top #(.FRAC_BITS(FracBits)) u_top (.*);

  always #4 clk_i = ~clk_i;

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor_frac(longint v);
    return v >>> FracBits;
  endfunction

  function automatic longint neg_div(longint num, longint den);
    longint n;
    n = (-num) * (64'sd1 <<< FracBits);
    return sat_word(n / den);
  endfunction

  function automatic lcp_out_t solve_contacts(lcp_in_t d);
    lcp_out_t r;
    longint a11, a21, a12, a22, b1, b2, c1, c2, y;
    a11 = longint'(d.a11); a21 = longint'(d.a21);
    a12 = longint'(d.a12); a22 = longint'(d.a22);
    b1 = longint'(d.bias1); b2 = longint'(d.bias2);
    r = '0;
    r.case_taken = CASE_ZERO;
    c1 = sat_word(floor_frac(-(longint'(d.inv11)) * b1 - longint'(d.inv12) * b2));
    c2 = sat_word(floor_frac(-(longint'(d.inv21)) * b1 - longint'(d.inv22) * b2));
    if (c1 >= 0 && c2 >= 0) begin
      r.impulse1 = 32'(c1); r.impulse2 = 32'(c2); r.solved = 1'b1;
      r.case_taken = CASE_FULL;
    end
    if (!r.solved && a11 != 0) begin
      c1 = neg_div(b1, a11);
      y = floor_frac(a21 * c1) + b2;
      if (c1 >= 0 && y >= 0) begin
        r.impulse1 = 32'(c1); r.impulse2 = '0; r.solved = 1'b1; r.case_taken = CASE_X1;
      end
    end
    if (!r.solved && a22 != 0) begin
      c2 = neg_div(b2, a22);
      y = floor_frac(a12 * c2) + b1;
      if (c2 >= 0 && y >= 0) begin
        r.impulse1 = '0; r.impulse2 = 32'(c2); r.solved = 1'b1; r.case_taken = CASE_X2;
      end
    end
    if (!r.solved) begin
      r.impulse1 = '0; r.impulse2 = '0; r.case_taken = CASE_ZERO;
      r.solved = (b1 >= 0 && b2 >= 0);
    end
    return r;
  endfunction

  task automatic send_contacts(lcp_in_t d);
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (in_stall_o);
    solution_q.push_back(solve_contacts(d));
  endtask

  task automatic idle_sender();
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
  endtask

  task automatic random_gap();
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      idle_sender();
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    idle_sender();
    while (solution_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 | $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return $urandom_range(0, 2) - 1;
      3: return $urandom;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  // Matrices near the identity with a matching inverse reach the solved cases.
  function automatic lcp_in_t rand_contacts();
    lcp_in_t d;
    logic [31:0] one;
    one = 32'h1 << FracBits;
    if ($urandom_range(0, 3) == 0) begin
      d = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
           rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
    end else begin
      d.a11 = one + $urandom_range(0, 32'h8000);
      d.a22 = one + $urandom_range(0, 32'h8000);
      d.a21 = $signed($urandom_range(0, 32'h1_0000)) - 32'sh8000;
      d.a12 = $signed($urandom_range(0, 32'h1_0000)) - 32'sh8000;
      d.inv11 = one - $urandom_range(0, 32'h4000);
      d.inv22 = one - $urandom_range(0, 32'h4000);
      d.inv21 = -d.a21;
      d.inv12 = -d.a12;
      d.bias1 = $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
      d.bias2 = $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
      if ($urandom_range(0, 7) == 0) d.a11 = '0;
      if ($urandom_range(0, 7) == 0) d.a22 = '0;
    end
    return d;
  endfunction

  task automatic test_directed();
    lcp_in_t d;
    logic [31:0] one;
    one = 32'h1 << FracBits;
    d = '0;
    send_contacts(d);
    d = '1;
    send_contacts(d);
    d = {10{32'h8000_0000}};
    send_contacts(d);
    d = {10{32'h7fff_ffff}};
    send_contacts(d);
    d = {one, 32'd0, 32'd0, one, one, 32'd0, 32'd0, one, -one, -one};
    send_contacts(d);
    d = {one, 32'd0, 32'd0, one, -one, 32'd0, 32'd0, one, -one, one};
    send_contacts(d);
    d = {one, one, 32'd0, one, -one, 32'd0, 32'd0, -one, one, -one};
    send_contacts(d);
    d = {32'd0, 32'd0, one, one, -one, 32'd0, 32'd0, -one, one, -one};
    send_contacts(d);
    d = {32'd0, 32'd0, 32'd0, 32'd0, -one, 32'd0, 32'd0, -one, one, one};
    send_contacts(d);
    d = {32'd0, 32'd0, 32'd0, 32'd0, one, 32'd0, 32'd0, one, -one, 32'd5};
    send_contacts(d);
    d = {32'd1, 32'd0, 32'd0, 32'd1, 32'h8000_0000, 32'd0, 32'd0, 32'h8000_0000,
         32'h8000_0000, 32'h8000_0000};
    send_contacts(d);
    d = {32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, {4{32'd0}},
         32'h8000_0000, 32'h8000_0000};
    send_contacts(d);
    d = {32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, {4{32'd0}},
         32'h7fff_ffff, 32'h7fff_ffff};
    send_contacts(d);
    d = {one, 32'h8000_0000, 32'h8000_0000, one, {4{32'd0}}, -one, -one};
    send_contacts(d);
    d = {32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
         32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa};
    send_contacts(d);
    drain();
  endtask

  task automatic test_random(int count);
    repeat (count) begin
      send_contacts(rand_contacts());
      random_gap();
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_cycles = 3 * Latency;
    repeat (Latency + 20) send_contacts(rand_contacts());
    drain();
  endtask

  task automatic test_steady();
    stall_random = 1'b0;
    repeat (150) send_contacts(rand_contacts());
    drain();
    stall_random = 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (stall_random) begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    lcp_out_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (solution_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        n_errors++;
      end else begin
        exp_r = solution_q.pop_front();
        if (out_data_o.impulse1 !== exp_r.impulse1) begin
          $display("%0t: impulse1 expected %h actual %h", $time, exp_r.impulse1,
                   out_data_o.impulse1);
          n_errors++;
        end
        if (out_data_o.impulse2 !== exp_r.impulse2) begin
          $display("%0t: impulse2 expected %h actual %h", $time, exp_r.impulse2,
                   out_data_o.impulse2);
          n_errors++;
        end
        if (out_data_o.solved !== exp_r.solved) begin
          $display("%0t: solved expected %b actual %b", $time, exp_r.solved,
                   out_data_o.solved);
          n_errors++;
        end
        if (out_data_o.case_taken !== exp_r.case_taken) begin
          $display("%0t: case_taken expected %0d actual %0d", $time, exp_r.case_taken,
                   out_data_o.case_taken);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(550);
    test_backpressure();
    test_steady();
    repeat (Latency + 10) @(posedge clk_i);
    if (n_errors == 0 && solution_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tclcp_pkg.sv
rtl/two_contact_lcp_solver_top.sv
test/testbench.sv
